// File: sv/pps_pkg.sv
`default_nettype none

package pps_pkg;

	// Field widths
	localparam int unsigned PRI_W  = 8;
	localparam int unsigned ARR_W  = 16;
	localparam int unsigned REM_W  = 16;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned TASK_W = 5;

	// Opcodes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef logic [PRI_W-1:0]  pri_t;
	typedef logic [ARR_W-1:0]  arr_t;
	typedef logic [REM_W-1:0]  rem_t;
	typedef logic [TIME_W-1:0] time_t;

endpackage

`default_nettype wire

// File: sv/preemptive_priority_scheduler_core.sv
`default_nettype none

// Load transfer: no result; the next input is taken in the following cycle.
// Tick transfer: one comparator walks the table one entry per cycle in the scan state, then
// a drain state and an update state register the result (an empty table goes straight to
// update); the next input is taken once the sequencer is back in idle.
// A tick waits in the update state while a previous result is still held on the output.
// Reset (arst_n low) clears task count, time, active count and control state, not the table.

module preemptive_priority_scheduler_core #(
	parameter int unsigned MAX_TASKS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,

	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        opcode,
	input  wire logic [pps_pkg::PRI_W-1:0]   task_priority,
	input  wire logic [pps_pkg::ARR_W-1:0]   task_arrival,
	input  wire logic [pps_pkg::REM_W-1:0]   task_burst,

	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [pps_pkg::TIME_W-1:0]       slot_time,
	output logic [pps_pkg::TASK_W-1:0]       running_task,
	output logic                             task_finished,
	output logic                             all_finished
);

	localparam int unsigned IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;
	localparam logic [1:0] ST_UPDATE = 2'd3;

	// Task table
	pps_pkg::pri_t mem_pri [MAX_TASKS];
	pps_pkg::arr_t mem_arr [MAX_TASKS];
	pps_pkg::rem_t mem_rem [MAX_TASKS];

	logic [1:0]       state_q;
	logic [CNT_W-1:0] loaded_q;
	logic [CNT_W-1:0] active_q;
	pps_pkg::time_t   time_q;
	logic [IDX_W-1:0] scan_idx_q;

	// Read stage of the scan
	logic             cmp_vld_s1;
	logic [IDX_W-1:0] cmp_idx_s1;
	pps_pkg::pri_t    rd_pri_s1;
	pps_pkg::arr_t    rd_arr_s1;
	pps_pkg::rem_t    rd_rem_s1;

	// Best candidate so far
	logic             found_q;
	logic [IDX_W-1:0] best_idx_q;
	pps_pkg::pri_t    best_pri_q;
	pps_pkg::arr_t    best_arr_q;
	pps_pkg::rem_t    best_rem_q;

	// Output register
	logic             out_valid_q;
	pps_pkg::time_t   slot_time_q;
	logic [pps_pkg::TASK_W-1:0] running_q;
	logic             finished_q;
	logic             all_done_q;

	logic             in_xfer;
	logic             load_xfer;
	logic             tick_xfer;
	logic             table_full;
	logic             scan_last;
	logic             arr_le;
	logic             cand_ok;
	logic             cand_better;
	logic             upd_fire;
	logic             finish_now;
	logic [CNT_W-1:0] active_next;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign load_xfer = in_xfer && (opcode == pps_pkg::OP_LOAD);
	assign tick_xfer = in_xfer && (opcode == pps_pkg::OP_TICK);
	assign table_full = (loaded_q >= CNT_W'(MAX_TASKS));
	assign scan_last = (CNT_W'(scan_idx_q) == (loaded_q - 1'b1));

	// Comparator: eligibility and ordering against the current best
	assign arr_le = (time_q[pps_pkg::TIME_W-1:pps_pkg::ARR_W] != '0) ||
		(rd_arr_s1 <= time_q[pps_pkg::ARR_W-1:0]);
	assign cand_ok = cmp_vld_s1 && (rd_rem_s1 != '0) && arr_le;
	assign cand_better = !found_q || (rd_pri_s1 < best_pri_q) ||
		((rd_pri_s1 == best_pri_q) && (rd_arr_s1 < best_arr_q));

	// Update step
	assign upd_fire    = (state_q == ST_UPDATE) && (!out_valid_q || !out_stall);
	assign finish_now  = found_q && (best_rem_q == pps_pkg::rem_t'(1));
	assign active_next = active_q - CNT_W'(finish_now);

	// Table writes: loads fill the next free row, the update decrements the winner
	always_ff @(posedge clk) begin
		if (load_xfer && !table_full) begin
			mem_pri[loaded_q[IDX_W-1:0]] <= task_priority;
			mem_arr[loaded_q[IDX_W-1:0]] <= task_arrival;
		end
		if (load_xfer && !table_full) begin
			mem_rem[loaded_q[IDX_W-1:0]] <= task_burst;
		end else if (upd_fire && found_q) begin
			mem_rem[best_idx_q] <= best_rem_q - 1'b1;
		end
	end

	// Registered table read at the scan index
	always_ff @(posedge clk) begin
		rd_pri_s1  <= mem_pri[scan_idx_q];
		rd_arr_s1  <= mem_arr[scan_idx_q];
		rd_rem_s1  <= mem_rem[scan_idx_q];
		cmp_idx_s1 <= scan_idx_q;
	end

	// Sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			loaded_q   <= '0;
			active_q   <= '0;
			time_q     <= '0;
			scan_idx_q <= '0;
			cmp_vld_s1 <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			cmp_vld_s1 <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (load_xfer && !table_full) begin
						loaded_q <= loaded_q + 1'b1;
						if (task_burst != '0) begin
							active_q <= active_q + 1'b1;
						end
					end
					if (tick_xfer) begin
						scan_idx_q <= '0;
						found_q    <= 1'b0;
						state_q    <= (loaded_q == '0) ? ST_UPDATE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					cmp_vld_s1 <= 1'b1;
					if (scan_last) begin
						state_q <= ST_DRAIN;
					end else begin
						scan_idx_q <= scan_idx_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (upd_fire) begin
						active_q <= active_next;
						if (time_q != '1) begin
							time_q <= time_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cand_ok && cand_better) begin
				found_q <= 1'b1;
			end
		end
	end

	// Best candidate payload
	always_ff @(posedge clk) begin
		if (cand_ok && cand_better) begin
			best_idx_q <= cmp_idx_s1;
			best_pri_q <= rd_pri_s1;
			best_arr_q <= rd_arr_s1;
			best_rem_q <= rd_rem_s1;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (upd_fire) begin
			slot_time_q <= time_q;
			running_q   <= found_q ?
				pps_pkg::TASK_W'(32'(best_idx_q) + 32'd1) : '0;
			finished_q  <= finish_now;
			all_done_q  <= (active_next == '0);
		end
	end

	assign out_valid     = out_valid_q;
	assign slot_time     = slot_time_q;
	assign running_task  = running_q;
	assign task_finished = finished_q;
	assign all_finished  = all_done_q;

	// Checks
	a_active_le_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		active_q <= loaded_q)
		else $error("active task count exceeds loaded count");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (CNT_W'(scan_idx_q) < loaded_q))
		else $error("scan index beyond loaded entries");

	a_time_advance: assert property (@(posedge clk) disable iff (!arst_n)
		upd_fire |=> ((time_q == $past(time_q) + 1'b1) || ($past(time_q) == '1)))
		else $error("time did not advance on a tick");

	a_finish_has_task: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && finished_q) |-> (running_q != '0))
		else $error("finish flagged on an idle slot");

	a_running_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (running_q != '0) && !finished_q) |-> !all_done_q)
		else $error("all work reported done while a task still has work");

endmodule

`default_nettype wire
